>>> rtl/core/mvpm_pkg.sv
// ----------------------------------------------------------------------------
// Multi-voice PCM mixer package
// Sizes, request codes and the command/status bundles shared by the mixer's
// controller, datapath and top level.
// ----------------------------------------------------------------------------
package mvpm_pkg;

  // Voice count and sample memory size
  localparam int VOICES           = 16;
  localparam int SAMPLE_ADDR_BITS = 16;
  localparam int MEM_WORDS        = 1 << SAMPLE_ADDR_BITS;

  // Voice number width, at least one bit
  localparam int VIDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;

  // Mix accumulator: each term stays below 2^16 in magnitude
  localparam int ACC_W = 18 + $clog2(VOICES);

  // Request codes
  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_START = 2'd1,
    REQ_GAIN  = 2'd2,
    REQ_LOAD  = 2'd3
  } req_e;

  // Controller to datapath commands
  typedef struct packed {
    logic              accept;    // latch request, clear accumulator
    logic              walk_en;   // issue one voice into the mix pipeline
    logic              search_en; // examine one voice for a start request
    logic              commit_en; // write the chosen voice
    logic              write_en;  // perform a gain or load write
    logic              load_rsp;  // capture the result into the output stage
    logic [VIDX_W-1:0] walk_idx;  // voice being visited
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic hit;      // visited voice is inactive
    logic out_free; // output stage can take a result
  } sts_t;

endpackage

>>> rtl/core/mvpm_stream_if.sv
// ----------------------------------------------------------------------------
// Mixer channel interfaces
// Valid/ready channels for the request and result transactions.
// ----------------------------------------------------------------------------
interface mvpm_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic [3:0]         voice_index;
  logic [15:0]        mem_address;
  logic [15:0]        sample_count;
  logic [15:0]        left_gain;
  logic [15:0]        right_gain;
  logic signed [15:0] load_value;

  modport source (
    output valid, req_type, voice_index, mem_address, sample_count,
           left_gain, right_gain, load_value,
    input  ready
  );
  modport sink (
    input  valid, req_type, voice_index, mem_address, sample_count,
           left_gain, right_gain, load_value,
    output ready
  );
endinterface

interface mvpm_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] left_out;
  logic signed [15:0] right_out;
  logic [3:0]         voice_taken;
  logic               voice_stolen;

  modport source (
    output valid, left_out, right_out, voice_taken, voice_stolen,
    input  ready
  );
  modport sink (
    input  valid, left_out, right_out, voice_taken, voice_stolen,
    output ready
  );
endinterface

>>> rtl/core/multi_voice_pcm_mixer.sv
// ----------------------------------------------------------------------------
// Multi-voice PCM mixer
// Sixteen sample-playback voices with voice stealing, mixed to a saturated
// stereo pair per tick.
// ----------------------------------------------------------------------------
// Every request transaction yields exactly one result transaction. The block
// takes one request at a time. A tick walks the voices one per cycle through
// a fetch/multiply/accumulate pipeline, which drains before the result is
// handed on. A start request scans voices one per cycle until the first free
// one or the last voice; gain and load requests perform one write. A finished
// result sits in an output register, so the next request can be taken while it
// waits; a result that finds that register still occupied holds the block until
// it is read. The sample memory has no reset: play only samples that were loaded.
module multi_voice_pcm_mixer (
  input  logic       clk_i,
  input  logic       rst_ni,
  mvpm_req_if.sink   req_i,
  mvpm_rsp_if.source rsp_o
);
  import mvpm_pkg::*;

  cmd_t cmd;
  sts_t sts;

  mvpm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_type_i  (req_i.req_type),
    .req_ready_o (req_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  mvpm_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .req_type_i     (req_i.req_type),
    .voice_index_i  (req_i.voice_index),
    .mem_address_i  (req_i.mem_address),
    .sample_count_i (req_i.sample_count),
    .left_gain_i    (req_i.left_gain),
    .right_gain_i   (req_i.right_gain),
    .load_value_i   (req_i.load_value),
    .rsp_valid_o    (rsp_o.valid),
    .rsp_ready_i    (rsp_o.ready),
    .left_out_o     (rsp_o.left_out),
    .right_out_o    (rsp_o.right_out),
    .voice_taken_o  (rsp_o.voice_taken),
    .voice_stolen_o (rsp_o.voice_stolen)
  );

  // A request closes the intake until its result is loaded into the output register
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready |=> !req_i.ready)
    else $error("request intake stayed open after a transaction");

  // A new result only appears while a request is in progress
  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_o.valid) |-> $past(!req_i.ready))
    else $error("result appeared with no request in progress");

  // Loading a result always presents it on the next cycle
  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_rsp |=> rsp_o.valid)
    else $error("result load did not raise valid");

endmodule

>>> rtl/core/mvpm_ctrl.sv
// ----------------------------------------------------------------------------
// Mixer controller
// Sequences each request: walks the voices for a tick or a start search,
// performs single-cycle writes, and hands the result to the output stage.
// ----------------------------------------------------------------------------
module mvpm_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  input  logic [1:0]    req_type_i,
  output logic          req_ready_o,
  input  mvpm_pkg::sts_t sts_i,
  output mvpm_pkg::cmd_t cmd_o
);
  import mvpm_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_TICK   = 8'b0000_0010,
    ST_DRAIN1 = 8'b0000_0100,
    ST_DRAIN2 = 8'b0000_1000,
    ST_SEARCH = 8'b0001_0000,
    ST_COMMIT = 8'b0010_0000,
    ST_WRITE  = 8'b0100_0000,
    ST_RESP   = 8'b1000_0000
  } state_e;

  localparam logic [VIDX_W-1:0] LAST_IDX = VIDX_W'(VOICES - 1);

  state_e            state_q, state_d;
  logic [VIDX_W-1:0] cnt_q, cnt_d;
  logic              accept;

  assign req_ready_o = (state_q == ST_IDLE);
  assign accept      = req_valid_i && req_ready_o;

  // Next state, walk counter and commands
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    cmd_o.accept   = accept;
    cmd_o.walk_idx = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (accept) begin
          unique case (req_e'(req_type_i))
            REQ_TICK:  state_d = ST_TICK;
            REQ_START: state_d = ST_SEARCH;
            REQ_GAIN:  state_d = ST_WRITE;
            REQ_LOAD:  state_d = ST_WRITE;
            default:   state_d = ST_WRITE;
          endcase
        end
      end
      ST_TICK: begin
        cmd_o.walk_en = 1'b1;
        if (cnt_q == LAST_IDX) begin
          cnt_d   = '0;
          state_d = ST_DRAIN1;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_DRAIN1: state_d = ST_DRAIN2;
      ST_DRAIN2: state_d = ST_RESP;
      ST_SEARCH: begin
        cmd_o.search_en = 1'b1;
        if (sts_i.hit || cnt_q == LAST_IDX) begin
          cnt_d   = '0;
          state_d = ST_COMMIT;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_COMMIT: begin
        cmd_o.commit_en = 1'b1;
        state_d         = ST_RESP;
      end
      ST_WRITE: begin
        cmd_o.write_en = 1'b1;
        state_d        = ST_RESP;
      end
      ST_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.load_rsp = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

>>> rtl/core/mvpm_datapath.sv
// ----------------------------------------------------------------------------
// Mixer datapath
// Voice registers, sample memory, a three-stage mix pipeline (fetch,
// multiply, accumulate), the start-request voice search and the output stage.
// ----------------------------------------------------------------------------
module mvpm_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mvpm_pkg::cmd_t     cmd_i,
  output mvpm_pkg::sts_t     sts_o,
  input  logic [1:0]         req_type_i,
  input  logic [3:0]         voice_index_i,
  input  logic [15:0]        mem_address_i,
  input  logic [15:0]        sample_count_i,
  input  logic [15:0]        left_gain_i,
  input  logic [15:0]        right_gain_i,
  input  logic signed [15:0] load_value_i,
  output logic               rsp_valid_o,
  input  logic               rsp_ready_i,
  output logic signed [15:0] left_out_o,
  output logic signed [15:0] right_out_o,
  output logic [3:0]         voice_taken_o,
  output logic               voice_stolen_o
);
  import mvpm_pkg::*;

  localparam int SAW = SAMPLE_ADDR_BITS;
  localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] SAT_MIN = -ACC_W'(32768);

  // Latched request
  req_e               req_type_q;
  logic [3:0]         vidx_q;
  logic [SAW-1:0]     addr_q;
  logic [15:0]        count_q;
  logic [15:0]        lgain_q;
  logic [15:0]        rgain_q;
  logic signed [15:0] lval_q;

  // Voice state
  logic           active_q [VOICES];
  logic [SAW-1:0] base_q   [VOICES];
  logic [15:0]    len_q    [VOICES];
  logic [15:0]    pos_q    [VOICES];
  logic [15:0]    lg_q     [VOICES];
  logic [15:0]    rg_q     [VOICES];

  // Sample memory
  logic signed [15:0] mem_q [MEM_WORDS];
  logic signed [15:0] rd_q;

  logic [VIDX_W-1:0] k;
  logic              play;
  logic [SAW-1:0]    rd_addr;
  logic              gain_hit;
  logic [VIDX_W-1:0] gain_idx;

  // Pipeline registers
  logic               s1_vld_q, s2_vld_q;
  logic [15:0]        s1_lg_q, s1_rg_q;
  logic signed [32:0] pl_q, pr_q;
  logic signed [ACC_W-1:0] accl_q, accr_q;

  // Search registers
  logic [VIDX_W-1:0] sel_q;
  logic [15:0]       far_pos_q;
  logic              stolen_q;

  logic signed [32:0] pl_b, pr_b;
  logic signed [17:0] tl, tr;
  logic signed [15:0] satl, satr;

  assign k        = cmd_i.walk_idx;
  assign play     = active_q[k] && (pos_q[k] < len_q[k]);
  assign rd_addr  = base_q[k] + SAW'(pos_q[k]);
  assign gain_hit = ({28'd0, vidx_q} < 32'(VOICES));
  assign gain_idx = VIDX_W'(vidx_q);

  assign sts_o.hit      = !active_q[k];
  assign sts_o.out_free = !rsp_valid_o || rsp_ready_i;

  // Latch request on acceptance
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      req_type_q <= req_e'(req_type_i);
      vidx_q     <= voice_index_i;
      addr_q     <= SAW'(mem_address_i);
      count_q    <= sample_count_i;
      lgain_q    <= left_gain_i;
      rgain_q    <= right_gain_i;
      lval_q     <= load_value_i;
    end
  end

  // Active flags: drop finished voices on a tick, set the chosen one on start
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < VOICES; i++) active_q[i] <= 1'b0;
    end else if (cmd_i.walk_en && active_q[k] && !play) begin
      active_q[k] <= 1'b0;
    end else if (cmd_i.commit_en) begin
      active_q[sel_q] <= 1'b1;
    end
  end

  // Voice fields: advance position, commit a start, update gains
  always_ff @(posedge clk_i) begin
    if (cmd_i.walk_en && play) begin
      pos_q[k] <= pos_q[k] + 16'd1;
    end
    if (cmd_i.commit_en) begin
      base_q[sel_q] <= addr_q;
      len_q[sel_q]  <= count_q;
      pos_q[sel_q]  <= '0;
      lg_q[sel_q]   <= lgain_q;
      rg_q[sel_q]   <= rgain_q;
    end
    if (cmd_i.write_en && req_type_q == REQ_GAIN && gain_hit) begin
      lg_q[gain_idx] <= lgain_q;
      rg_q[gain_idx] <= rgain_q;
    end
  end

  // Sample memory: load writes, tick fetches
  always_ff @(posedge clk_i) begin
    if (cmd_i.write_en && req_type_q == REQ_LOAD) begin
      mem_q[addr_q] <= lval_q;
    end
    if (cmd_i.walk_en) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  // Search: first inactive voice, else the farthest one (lowest on a tie)
  always_ff @(posedge clk_i) begin
    if (cmd_i.search_en) begin
      if (!active_q[k]) begin
        sel_q    <= k;
        stolen_q <= 1'b0;
      end else if (k == '0 || pos_q[k] > far_pos_q) begin
        sel_q     <= k;
        far_pos_q <= pos_q[k];
        stolen_q  <= 1'b1;
      end
    end
  end

  // Mix pipeline valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= cmd_i.walk_en && play;
      s2_vld_q <= s1_vld_q;
    end
  end

  // Stage 1: capture gains; stage 2: multiply
  always_ff @(posedge clk_i) begin
    if (cmd_i.walk_en) begin
      s1_lg_q <= lg_q[k];
      s1_rg_q <= rg_q[k];
    end
    pl_q <= rd_q * $signed({1'b0, s1_lg_q});
    pr_q <= rd_q * $signed({1'b0, s1_rg_q});
  end

  // Scale by 1/32768, truncating toward zero
  always_comb begin
    pl_b = pl_q[32] ? pl_q + 33'sd32767 : pl_q;
    pr_b = pr_q[32] ? pr_q + 33'sd32767 : pr_q;
    tl   = pl_b[32:15];
    tr   = pr_b[32:15];
  end

  // Stage 3: accumulate
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      accl_q <= '0;
      accr_q <= '0;
    end else if (s2_vld_q) begin
      accl_q <= accl_q + ACC_W'(tl);
      accr_q <= accr_q + ACC_W'(tr);
    end
  end

  // Saturate the sums to 16 bits
  always_comb begin
    if (accl_q > SAT_MAX)      satl = 16'sh7fff;
    else if (accl_q < SAT_MIN) satl = -16'sh8000;
    else                       satl = accl_q[15:0];
    if (accr_q > SAT_MAX)      satr = 16'sh7fff;
    else if (accr_q < SAT_MIN) satr = -16'sh8000;
    else                       satr = accr_q[15:0];
  end

  // Output stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_o <= 1'b0;
    end else if (cmd_i.load_rsp) begin
      rsp_valid_o <= 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_rsp) begin
      unique case (req_type_q)
        REQ_TICK: begin
          left_out_o     <= satl;
          right_out_o    <= satr;
          voice_taken_o  <= '0;
          voice_stolen_o <= 1'b0;
        end
        REQ_START: begin
          left_out_o     <= '0;
          right_out_o    <= '0;
          voice_taken_o  <= 4'(sel_q);
          voice_stolen_o <= stolen_q;
        end
        default: begin
          left_out_o     <= '0;
          right_out_o    <= '0;
          voice_taken_o  <= '0;
          voice_stolen_o <= 1'b0;
        end
      endcase
    end
  end

endmodule
